// ===== hw/rtl/uer_pkg.sv =====
`timescale 1ns / 1ps

package uer_pkg;

    localparam int DIST_W      = 15;
    localparam int STATUS_W    = 2;
    localparam int CFG_INDEX_W = 8;
    localparam int CFG_DATA_W  = 16;

    localparam logic [DIST_W-1:0] DIST_MAX = 15'h7FFF;

    localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NO_ECHO  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_TOO_LONG = 2'd2;

    localparam logic [7:0]  RST_TRIG_LOW  = 8'd2;
    localparam logic [7:0]  RST_TRIG_HIGH = 8'd20;
    localparam logic [15:0] RST_TIMEOUT   = 16'd60000;
    localparam logic [7:0]  RST_DIVISOR   = 8'd58;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_TRIG_LOW  = 8'd0,
        REG_TRIG_HIGH = 8'd1,
        REG_TIMEOUT   = 8'd2,
        REG_DIVISOR   = 8'd3
    } reg_idx_t;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_TLOW,
        PH_THIGH,
        PH_WAIT,
        PH_MEAS,
        PH_DIV
    } phase_t;

    typedef struct packed {
        logic                cnt_clear;
        logic                cnt_inc;
        logic                div_start;
        logic                fin_err;
        logic                fin_ok;
        logic [STATUS_W-1:0] err_status;
        logic                out_load;
        logic                out_trig;
        logic                out_busy;
        logic                out_done;
    } dp_cmd_t;

    typedef struct packed {
        logic ge_low;
        logic ge_high;
        logic timed_out;
        logic div_done;
    } dp_stat_t;

endpackage

// ===== hw/rtl/uer_tick_if.sv =====
`timescale 1ns / 1ps

interface uer_tick_if;
    logic valid;
    logic ready;
    logic start_request;
    logic echo_level;

    modport source (output valid, output start_request, output echo_level, input ready);
    modport sink (input valid, input start_request, input echo_level, output ready);
endinterface

// ===== hw/rtl/uer_result_if.sv =====
`timescale 1ns / 1ps

interface uer_result_if;
    logic                           valid;
    logic                           ready;
    logic                           trigger_level;
    logic                           busy_res;
    logic                           done_res;
    logic [uer_pkg::STATUS_W-1:0]   measure_status;
    logic [uer_pkg::DIST_W-1:0]     distance_cm;

    modport source (
        output valid, output trigger_level, output busy_res, output done_res,
        output measure_status, output distance_cm, input ready
    );
    modport sink (
        input valid, input trigger_level, input busy_res, input done_res,
        input measure_status, input distance_cm, output ready
    );
endinterface

// ===== hw/rtl/uer_cfg_if.sv =====
`timescale 1ns / 1ps

interface uer_cfg_if;
    logic                             valid;
    logic                             ready;
    logic [uer_pkg::CFG_INDEX_W-1:0]  index;
    logic [uer_pkg::CFG_DATA_W-1:0]   data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

// ===== hw/rtl/uer_ctrl.sv =====
`timescale 1ns / 1ps

module uer_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               tick_valid,
    input  logic               start_request,
    input  logic               echo_level,
    output logic               tick_ready,
    output logic               result_valid,
    input  logic               result_ready,
    input  uer_pkg::dp_stat_t  stat,
    output uer_pkg::dp_cmd_t   cmd
);

    uer_pkg::phase_t phase_reg;
    uer_pkg::phase_t phase_next;
    logic            out_valid_reg;
    logic            out_valid_next;
    logic            out_free;
    logic            accept;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= uer_pkg::PH_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg     <= phase_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        out_free       = !out_valid_reg || result_ready;
        tick_ready     = (phase_reg != uer_pkg::PH_DIV) && out_free;
        accept         = tick_valid && tick_ready;
        phase_next     = phase_reg;
        out_valid_next = out_valid_reg && !result_ready;
        cmd            = '0;

        case (phase_reg)
            uer_pkg::PH_IDLE:
            begin
                if (accept && start_request)
                begin
                    phase_next    = uer_pkg::PH_TLOW;
                    cmd.cnt_clear = 1'b1;
                end
            end
            uer_pkg::PH_TLOW:
            begin
                if (accept)
                begin
                    cmd.cnt_inc = 1'b1;
                    if (stat.ge_low)
                    begin
                        phase_next    = uer_pkg::PH_THIGH;
                        cmd.cnt_clear = 1'b1;
                    end
                end
            end
            uer_pkg::PH_THIGH:
            begin
                cmd.out_trig = 1'b1;
                if (accept)
                begin
                    cmd.cnt_inc = 1'b1;
                    if (stat.ge_high)
                    begin
                        phase_next    = uer_pkg::PH_WAIT;
                        cmd.cnt_clear = 1'b1;
                    end
                end
            end
            uer_pkg::PH_WAIT:
            begin
                if (accept)
                begin
                    if (echo_level)
                    begin
                        phase_next    = uer_pkg::PH_MEAS;
                        cmd.cnt_clear = 1'b1;
                    end
                    else
                    begin
                        cmd.cnt_inc = 1'b1;
                        if (stat.timed_out)
                        begin
                            phase_next     = uer_pkg::PH_IDLE;
                            cmd.cnt_clear  = 1'b1;
                            cmd.fin_err    = 1'b1;
                            cmd.err_status = uer_pkg::ST_NO_ECHO;
                            cmd.out_done   = 1'b1;
                        end
                    end
                end
            end
            uer_pkg::PH_MEAS:
            begin
                if (accept)
                begin
                    if (!echo_level)
                    begin
                        phase_next    = uer_pkg::PH_DIV;
                        cmd.div_start = 1'b1;
                    end
                    else
                    begin
                        cmd.cnt_inc = 1'b1;
                        if (stat.timed_out)
                        begin
                            phase_next     = uer_pkg::PH_IDLE;
                            cmd.cnt_clear  = 1'b1;
                            cmd.fin_err    = 1'b1;
                            cmd.err_status = uer_pkg::ST_TOO_LONG;
                            cmd.out_done   = 1'b1;
                        end
                    end
                end
            end
            uer_pkg::PH_DIV:
            begin
                // echo fell: result loads once the quotient is complete and the result register is free
                if (stat.div_done && out_free)
                begin
                    phase_next     = uer_pkg::PH_IDLE;
                    cmd.cnt_clear  = 1'b1;
                    cmd.fin_ok     = 1'b1;
                    cmd.out_done   = 1'b1;
                    cmd.out_load   = 1'b1;
                    out_valid_next = 1'b1;
                end
            end
            default:
            begin
                phase_next    = uer_pkg::PH_IDLE;
                cmd.cnt_clear = 1'b1;
            end
        endcase

        if (accept && !cmd.div_start)
        begin
            cmd.out_load   = 1'b1;
            out_valid_next = 1'b1;
        end
        cmd.out_busy = (phase_next != uer_pkg::PH_IDLE);
        result_valid = out_valid_reg;
    end

endmodule

// ===== hw/rtl/uer_datapath.sv =====
`timescale 1ns / 1ps

module uer_datapath #(
    parameter int COUNTER_BITS = 16
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  uer_pkg::dp_cmd_t                   cmd,
    output uer_pkg::dp_stat_t                  stat,
    input  logic                               cfg_valid,
    input  logic [uer_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [uer_pkg::CFG_DATA_W-1:0]     cfg_data,
    output logic                               trigger_level,
    output logic                               busy_res,
    output logic                               done_res,
    output logic [uer_pkg::STATUS_W-1:0]       measure_status,
    output logic [uer_pkg::DIST_W-1:0]         distance_cm
);

    localparam int QW   = COUNTER_BITS - 1;
    localparam int DCW  = $clog2(QW + 1);
    localparam int CMPW = (COUNTER_BITS > 16) ? COUNTER_BITS : 16;
    localparam int QXW  = (QW > uer_pkg::DIST_W) ? QW : uer_pkg::DIST_W;

    logic [7:0]                     trig_low_reg;
    logic [7:0]                     trig_high_reg;
    logic [15:0]                    timeout_reg;
    logic [7:0]                     divisor_reg;

    logic [COUNTER_BITS-1:0]        cnt_reg;
    logic [COUNTER_BITS-1:0]        cnt_next;
    logic [COUNTER_BITS-1:0]        cnt_inc_val;

    logic [QW-1:0]                  dq_reg;
    logic [7:0]                     rem_reg;
    logic [DCW-1:0]                 div_cnt_reg;
    logic [7:0]                     div_eff;
    logic [8:0]                     trial;
    logic [8:0]                     diff;
    logic                           q_bit;
    logic [QXW-1:0]                 q_ext;
    logic [uer_pkg::DIST_W-1:0]     dist_sat;

    logic [uer_pkg::STATUS_W-1:0]   last_status_reg;
    logic [uer_pkg::STATUS_W-1:0]   last_status_next;
    logic [uer_pkg::DIST_W-1:0]     last_dist_reg;
    logic [uer_pkg::DIST_W-1:0]     last_dist_next;

    logic                           out_trig_reg;
    logic                           out_busy_reg;
    logic                           out_done_reg;
    logic [uer_pkg::STATUS_W-1:0]   out_status_reg;
    logic [uer_pkg::DIST_W-1:0]     out_dist_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            trig_low_reg  <= uer_pkg::RST_TRIG_LOW;
            trig_high_reg <= uer_pkg::RST_TRIG_HIGH;
            timeout_reg   <= uer_pkg::RST_TIMEOUT;
            divisor_reg   <= uer_pkg::RST_DIVISOR;
        end
        else if (cfg_valid)
        begin
            case (uer_pkg::reg_idx_t'(cfg_index))
                uer_pkg::REG_TRIG_LOW:  trig_low_reg  <= cfg_data[7:0];
                uer_pkg::REG_TRIG_HIGH: trig_high_reg <= cfg_data[7:0];
                uer_pkg::REG_TIMEOUT:   timeout_reg   <= cfg_data;
                uer_pkg::REG_DIVISOR:   divisor_reg   <= cfg_data[7:0];
                default:
                begin
                end
            endcase
        end
    end

    // saturating tick counter
    always_comb
    begin
        cnt_inc_val = (cnt_reg == '1) ? cnt_reg : cnt_reg + COUNTER_BITS'(1);
        if (cmd.cnt_clear)
            cnt_next = '0;
        else if (cmd.cnt_inc)
            cnt_next = cnt_inc_val;
        else
            cnt_next = cnt_reg;

        stat.ge_low    = cnt_inc_val >= COUNTER_BITS'(trig_low_reg);
        stat.ge_high   = cnt_inc_val >= COUNTER_BITS'(trig_high_reg);
        stat.timed_out = (CMPW'(cnt_inc_val) > CMPW'(timeout_reg)) || (cnt_inc_val == '1);
        stat.div_done  = (div_cnt_reg == '0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cnt_reg <= '0;
        else
            cnt_reg <= cnt_next;
    end

    // restoring divider, one quotient bit per cycle
    always_comb
    begin
        div_eff  = (divisor_reg == 8'd0) ? 8'd1 : divisor_reg;
        trial    = {rem_reg, dq_reg[QW-1]};
        diff     = trial - {1'b0, div_eff};
        q_bit    = (trial >= {1'b0, div_eff});
        q_ext    = QXW'(dq_reg);
        dist_sat = (q_ext > QXW'(uer_pkg::DIST_MAX)) ? uer_pkg::DIST_MAX
                                                     : q_ext[uer_pkg::DIST_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            div_cnt_reg <= '0;
        else if (cmd.div_start)
            div_cnt_reg <= DCW'(QW);
        else if (div_cnt_reg != '0)
            div_cnt_reg <= div_cnt_reg - DCW'(1);
    end

    always_ff @(posedge clk)
    begin
        if (cmd.div_start)
        begin
            dq_reg  <= cnt_reg[COUNTER_BITS-1:1];
            rem_reg <= 8'd0;
        end
        else if (div_cnt_reg != '0)
        begin
            dq_reg  <= {dq_reg[QW-2:0], q_bit};
            rem_reg <= q_bit ? diff[7:0] : trial[7:0];
        end
    end

    always_comb
    begin
        last_status_next = last_status_reg;
        last_dist_next   = last_dist_reg;
        if (cmd.fin_err)
        begin
            last_status_next = cmd.err_status;
            last_dist_next   = '0;
        end
        else if (cmd.fin_ok)
        begin
            last_status_next = uer_pkg::ST_OK;
            last_dist_next   = dist_sat;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_status_reg <= uer_pkg::ST_OK;
            last_dist_reg   <= '0;
        end
        else
        begin
            last_status_reg <= last_status_next;
            last_dist_reg   <= last_dist_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            out_trig_reg   <= cmd.out_trig;
            out_busy_reg   <= cmd.out_busy;
            out_done_reg   <= cmd.out_done;
            out_status_reg <= last_status_next;
            out_dist_reg   <= last_dist_next;
        end
    end

    assign trigger_level  = out_trig_reg;
    assign busy_res       = out_busy_reg;
    assign done_res       = out_done_reg;
    assign measure_status = out_status_reg;
    assign distance_cm    = out_dist_reg;

endmodule

// ===== hw/rtl/ultrasonic_echo_ranger.sv =====
`timescale 1ns / 1ps

// Channel   Dir   Request                                      Ready
// tick      in    start_request, echo_level (one timer tick)   result reg free, divider idle
// result    out   trigger_level, busy_res, done_res,           from downstream
//                 measure_status, distance_cm
// cfg       in    index, data (register write)                 always high
//
// Each tick's result sits in an output register, and the next tick is taken while that
// register drains. The tick on which the echo falls starts the restoring divider, which
// yields one of COUNTER_BITS - 1 quotient bits per cycle; tick intake waits until it ends.
// Reset clears phase, tick counter and last status/distance, and loads register defaults.
// A stalled result stalls tick intake; configuration writes are taken in any cycle.

module ultrasonic_echo_ranger #(
    parameter int COUNTER_BITS = 16
) (
    input  logic                clk,
    input  logic                rst_n,
    uer_tick_if.sink            tick,
    uer_result_if.source        result,
    uer_cfg_if.sink             cfg
);

    uer_pkg::dp_cmd_t  cmd;
    uer_pkg::dp_stat_t stat;

    assign cfg.ready = 1'b1;

    uer_ctrl u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .tick_valid    (tick.valid),
        .start_request (tick.start_request),
        .echo_level    (tick.echo_level),
        .tick_ready    (tick.ready),
        .result_valid  (result.valid),
        .result_ready  (result.ready),
        .stat          (stat),
        .cmd           (cmd)
    );

    uer_datapath #(
        .COUNTER_BITS (COUNTER_BITS)
    ) u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .stat           (stat),
        .cfg_valid      (cfg.valid),
        .cfg_index      (cfg.index),
        .cfg_data       (cfg.data),
        .trigger_level  (result.trigger_level),
        .busy_res       (result.busy_res),
        .done_res       (result.done_res),
        .measure_status (result.measure_status),
        .distance_cm    (result.distance_cm)
    );

endmodule

// ===== hw/rtl/uer_checker.sv =====
`timescale 1ns / 1ps

module uer_checker (
    input logic                             clk,
    input logic                             rst_n,
    input logic                             tick_valid,
    input logic                             tick_ready,
    input logic                             result_valid,
    input logic                             result_ready,
    input logic                             trigger_level,
    input logic                             busy_res,
    input logic                             done_res,
    input logic [uer_pkg::STATUS_W-1:0]     measure_status,
    input logic [uer_pkg::DIST_W-1:0]       distance_cm
);

    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid && $stable(distance_cm)
        && $stable(measure_status) && $stable(done_res))
        else $error("result changed while stalled");

    a_no_take_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |-> !(tick_valid && tick_ready))
        else $error("tick taken while result stalled");

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && (done_res || trigger_level) |-> (busy_res != done_res))
        else $error("done/trigger inconsistent with busy");

    a_err_dist: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && measure_status != uer_pkg::ST_OK |-> distance_cm == '0)
        else $error("nonzero distance on error status");

endmodule

bind ultrasonic_echo_ranger uer_checker u_uer_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .tick_valid     (tick.valid),
    .tick_ready     (tick.ready),
    .result_valid   (result.valid),
    .result_ready   (result.ready),
    .trigger_level  (result.trigger_level),
    .busy_res       (result.busy_res),
    .done_res       (result.done_res),
    .measure_status (result.measure_status),
    .distance_cm    (result.distance_cm)
);
